[design/scatr_pkg.sv]
package scatr_pkg;

    // Parse phases of one Answer-to-Reset.
    typedef enum logic [2:0] {
        PH_TS,
        PH_T0,
        PH_IFACE,
        PH_HIST,
        PH_TCK,
        PH_DRAIN
    } phase_t;

    // Result error codes.
    localparam logic [2:0] ERR_NONE  = 3'd0;
    localparam logic [2:0] ERR_TS    = 3'd1;
    localparam logic [2:0] ERR_TD    = 3'd2;
    localparam logic [2:0] ERR_TA2   = 3'd3;
    localparam logic [2:0] ERR_LONG  = 3'd4;
    localparam logic [2:0] ERR_TRUNC = 3'd5;

    // TS byte values.
    localparam logic [7:0] TS_INVERSE = 8'h3F;
    localparam logic [7:0] TS_DIRECT  = 8'h3B;

    // Coding conventions.
    localparam logic [1:0] CONV_NONE    = 2'd0;
    localparam logic [1:0] CONV_DIRECT  = 2'd1;
    localparam logic [1:0] CONV_INVERSE = 2'd2;

    // Available protocol mask bits.
    localparam logic [3:0] PROT_T0  = 4'h1;
    localparam logic [3:0] PROT_T1  = 4'h2;
    localparam logic [3:0] PROT_T15 = 4'h8;

    // Default protocol codes.
    localparam logic [1:0] DEF_NONE = 2'd0;
    localparam logic [1:0] DEF_T0   = 2'd1;
    localparam logic [1:0] DEF_T1   = 2'd2;

    // Protocol numbers carried in the low nibble of TD and TA2.
    localparam logic [3:0] TNUM_T0  = 4'd0;
    localparam logic [3:0] TNUM_T1  = 4'd1;
    localparam logic [3:0] TNUM_T15 = 4'd15;

    localparam logic [5:0] COUNT_MAX = 6'd63;

    typedef struct packed {
        phase_t     phase;
        logic [3:0] presence_mask;
        logic [5:0] group_index;
        logic [3:0] remaining_history;
        logic [3:0] history_count;
        logic [5:0] byte_count;
        logic [4:0] ta_low_nibble;
        logic [1:0] current_protocol;
        logic [3:0] protocol_mask;
        logic [1:0] coding_convention;
    } state_t;

    localparam state_t RESET_STATE = '{
        phase:             PH_TS,
        presence_mask:     4'd0,
        group_index:       6'd1,
        remaining_history: 4'd0,
        history_count:     4'd0,
        byte_count:        6'd0,
        ta_low_nibble:     5'd0,
        current_protocol:  DEF_NONE,
        protocol_mask:     4'd0,
        coding_convention: CONV_NONE
    };

    typedef struct packed {
        logic       decode_ok;
        logic [2:0] error_code;
        logic [1:0] default_protocol;
        logic [3:0] available_protocols;
        logic [1:0] convention;
        logic [3:0] history_length;
        logic [5:0] atr_length;
    } result_t;

endpackage

[design/smart_card_atr_parser.sv]
// Streaming Answer-to-Reset parser for ISO 7816-3 smart cards.
// The byte channel (byte_valid / byte_stall) carries one ATR byte per
// transaction, starting with TS; is_last marks the final byte supplied for
// this ATR, after which the parser rearms for the next one.
// The result channel (result_valid / result_stall) carries at most one
// transaction per ATR: the decoded summary on success, or an error code as
// soon as the ATR is found to be bad or ends early. Bytes that follow a
// result are dropped until is_last arrives.
// Each accepted byte lands in an input register and, once it may advance, is
// decoded by one pass of combinational logic into the result register, from
// which the result is offered on the result channel.
// Throughput is one byte per cycle; the only limit is the result register.
// When the receiver stalls with a result pending, the parser keeps taking
// bytes that produce no result and only holds off a byte that would
// produce a second result; byte_stall then rises.
// Reset clears the parse state to "expect TS" and empties both registers.
module smart_card_atr_parser #(
    parameter int MAX_ATR_BYTES = 33
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       byte_valid,
    output logic       byte_stall,
    input  logic [7:0] atr_byte,
    input  logic       is_last,
    output logic       result_valid,
    input  logic       result_stall,
    output logic       decode_ok,
    output logic [2:0] error_code,
    output logic [1:0] default_protocol,
    output logic [3:0] available_protocols,
    output logic [1:0] convention,
    output logic [3:0] history_length,
    output logic [5:0] atr_length
);

    logic               in_valid_reg;
    logic [7:0]         in_byte_reg;
    logic               in_last_reg;
    scatr_pkg::state_t  state_reg;
    scatr_pkg::state_t  state_next;
    logic               emit;
    logic               advance;
    scatr_pkg::result_t step_result;
    logic               out_valid_reg;
    scatr_pkg::result_t out_reg;

    scatr_step #(
        .MAX_ATR_BYTES(MAX_ATR_BYTES)
    ) u_step (
        .state_cur (state_reg),
        .atr_byte  (in_byte_reg),
        .is_last   (in_last_reg),
        .state_new (state_next),
        .emit      (emit),
        .result    (step_result)
    );

    // The buffered byte waits only if it would produce a result while the
    // result register is still held by the receiver.
    assign advance    = in_valid_reg && !(emit && out_valid_reg && result_stall);
    assign byte_stall = in_valid_reg && !advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!byte_stall)
        begin
            in_valid_reg <= byte_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!byte_stall && byte_valid)
        begin
            in_byte_reg <= atr_byte;
            in_last_reg <= is_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= scatr_pkg::RESET_STATE;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && emit)
        begin
            out_reg <= step_result;
        end
    end

    assign result_valid        = out_valid_reg;
    assign decode_ok           = out_reg.decode_ok;
    assign error_code          = out_reg.error_code;
    assign default_protocol    = out_reg.default_protocol;
    assign available_protocols = out_reg.available_protocols;
    assign convention          = out_reg.convention;
    assign history_length      = out_reg.history_length;
    assign atr_length          = out_reg.atr_length;

endmodule

[design/scatr_step.sv]
module scatr_step #(
    parameter int MAX_ATR_BYTES = 33
) (
    input  scatr_pkg::state_t  state_cur,
    input  logic [7:0]         atr_byte,
    input  logic               is_last,
    output scatr_pkg::state_t  state_new,
    output logic               emit,
    output scatr_pkg::result_t result
);

    localparam logic [5:0] MAX_BYTES = 6'(MAX_ATR_BYTES);

    typedef struct packed {
        scatr_pkg::state_t s;
        logic              busy;
        logic [2:0]        err;
    } step_t;

    // Closes an interface group; y is the presence nibble of the next group.
    function automatic step_t end_group(input scatr_pkg::state_t s, input logic [3:0] y);
        step_t r;
        r.s    = s;
        r.busy = 1'b1;
        r.err  = scatr_pkg::ERR_NONE;
        if (s.byte_count > MAX_BYTES) begin
            r.busy = 1'b0;
            r.err  = scatr_pkg::ERR_LONG;
        end else if (y != 4'd0) begin
            if (s.group_index != scatr_pkg::COUNT_MAX) begin
                r.s.group_index = s.group_index + 6'd1;
            end
            r.s.presence_mask = y;
            r.s.ta_low_nibble = 5'd0;
            r.s.phase         = scatr_pkg::PH_IFACE;
        end else begin
            if (s.current_protocol == scatr_pkg::DEF_NONE) begin
                r.s.current_protocol = scatr_pkg::DEF_T0;
                r.s.protocol_mask    = s.protocol_mask | scatr_pkg::PROT_T0;
            end
            if (s.history_count != 4'd0) begin
                r.s.remaining_history = s.history_count;
                r.s.phase             = scatr_pkg::PH_HIST;
            end else if ((r.s.protocol_mask & scatr_pkg::PROT_T1) != 4'd0) begin
                r.s.phase = scatr_pkg::PH_TCK;
            end else begin
                r.busy = 1'b0;
            end
        end
        return r;
    endfunction

    function automatic step_t take_td(input scatr_pkg::state_t s, input logic [7:0] b);
        step_t             r;
        scatr_pkg::state_t t;
        logic              fail;
        logic [2:0]        code;
        t    = s;
        fail = 1'b0;
        code = scatr_pkg::ERR_NONE;
        if (t.current_protocol == scatr_pkg::DEF_NONE) begin
            priority if (b[3:0] == scatr_pkg::TNUM_T0) begin
                t.current_protocol = scatr_pkg::DEF_T0;
            end else if (b[3:0] == scatr_pkg::TNUM_T1) begin
                t.current_protocol = scatr_pkg::DEF_T1;
            end else begin
                fail = 1'b1;
                code = scatr_pkg::ERR_TD;
            end
        end
        if (!fail) begin
            priority if (b[3:0] == scatr_pkg::TNUM_T0) begin
                t.protocol_mask = t.protocol_mask | scatr_pkg::PROT_T0;
            end else if (b[3:0] == scatr_pkg::TNUM_T1) begin
                t.protocol_mask = t.protocol_mask | scatr_pkg::PROT_T1;
            end else if (b[3:0] == scatr_pkg::TNUM_T15) begin
                t.protocol_mask = t.protocol_mask | scatr_pkg::PROT_T15;
            end else begin
                t.protocol_mask = t.protocol_mask;
            end
            // A TA2 takes effect only once TD2 confirms the group.
            if (t.group_index == 6'd2 && t.ta_low_nibble[4]) begin
                priority if (t.ta_low_nibble[3:0] == scatr_pkg::TNUM_T0) begin
                    t.current_protocol = scatr_pkg::DEF_T0;
                    t.protocol_mask    = scatr_pkg::PROT_T0;
                end else if (t.ta_low_nibble[3:0] == scatr_pkg::TNUM_T1) begin
                    t.current_protocol = scatr_pkg::DEF_T1;
                    t.protocol_mask    = scatr_pkg::PROT_T1;
                end else begin
                    fail = 1'b1;
                    code = scatr_pkg::ERR_TA2;
                end
            end
        end
        if (fail) begin
            r.s    = t;
            r.busy = 1'b0;
            r.err  = code;
        end else begin
            t.presence_mask = 4'd0;
            r = end_group(t, b[7:4]);
        end
        return r;
    endfunction

    function automatic step_t take_iface(input scatr_pkg::state_t s, input logic [7:0] b);
        step_t             r;
        scatr_pkg::state_t t;
        logic              check_end;
        t         = s;
        check_end = 1'b1;
        r.s       = s;
        r.busy    = 1'b1;
        r.err     = scatr_pkg::ERR_NONE;
        priority if (s.presence_mask[0]) begin
            t.presence_mask = s.presence_mask & 4'hE;
            t.ta_low_nibble = {1'b1, b[3:0]};
        end else if (s.presence_mask[1]) begin
            t.presence_mask = s.presence_mask & 4'hC;
        end else if (s.presence_mask[2]) begin
            t.presence_mask = s.presence_mask & 4'h8;
        end else if (s.presence_mask[3]) begin
            check_end = 1'b0;
            r = take_td(s, b);
        end else begin
            check_end = 1'b0;
            r = end_group(s, 4'd0);
        end
        if (check_end) begin
            if (t.presence_mask == 4'd0) begin
                r = end_group(t, 4'd0);
            end else begin
                r.s = t;
            end
        end
        return r;
    endfunction

    scatr_pkg::state_t cur;
    step_t             sr;

    always_comb begin
        cur = state_cur;
        if (state_cur.byte_count != scatr_pkg::COUNT_MAX) begin
            cur.byte_count = state_cur.byte_count + 6'd1;
        end
        sr.s    = cur;
        sr.busy = 1'b1;
        sr.err  = scatr_pkg::ERR_NONE;
        unique case (state_cur.phase)
            scatr_pkg::PH_TS:
            begin
                priority if (atr_byte == scatr_pkg::TS_INVERSE) begin
                    sr.s.coding_convention = scatr_pkg::CONV_INVERSE;
                    sr.s.phase             = scatr_pkg::PH_T0;
                end else if (atr_byte == scatr_pkg::TS_DIRECT) begin
                    sr.s.coding_convention = scatr_pkg::CONV_DIRECT;
                    sr.s.phase             = scatr_pkg::PH_T0;
                end else begin
                    sr.busy = 1'b0;
                    sr.err  = scatr_pkg::ERR_TS;
                end
            end
            scatr_pkg::PH_T0:
            begin
                sr.s.history_count = atr_byte[3:0];
                sr.s.group_index   = 6'd1;
                sr.s.ta_low_nibble = 5'd0;
                sr.s.presence_mask = atr_byte[7:4];
                if (atr_byte[7:4] == 4'd0) begin
                    sr = end_group(sr.s, 4'd0);
                end else begin
                    sr.s.phase = scatr_pkg::PH_IFACE;
                end
            end
            scatr_pkg::PH_IFACE:
            begin
                sr = take_iface(cur, atr_byte);
            end
            scatr_pkg::PH_HIST:
            begin
                if (cur.remaining_history != 4'd0) begin
                    sr.s.remaining_history = cur.remaining_history - 4'd1;
                end
                if (sr.s.remaining_history == 4'd0) begin
                    if ((cur.protocol_mask & scatr_pkg::PROT_T1) != 4'd0) begin
                        sr.s.phase = scatr_pkg::PH_TCK;
                    end else begin
                        sr.busy = 1'b0;
                    end
                end
            end
            default:
            begin
                // TCK is consumed without a check.
                sr.busy = 1'b0;
            end
        endcase

        if (sr.busy && is_last) begin
            sr.busy = 1'b0;
            sr.err  = scatr_pkg::ERR_TRUNC;
        end

        if (state_cur.phase == scatr_pkg::PH_DRAIN) begin
            // Bytes after a result are dropped until the last one rearms.
            emit      = 1'b0;
            state_new = state_cur;
            if (is_last) begin
                state_new = scatr_pkg::RESET_STATE;
            end
        end else begin
            emit      = !sr.busy;
            state_new = sr.s;
            if (emit) begin
                if (is_last) begin
                    state_new = scatr_pkg::RESET_STATE;
                end else begin
                    state_new.phase = scatr_pkg::PH_DRAIN;
                end
            end
        end

        result.atr_length = cur.byte_count;
        if (sr.err == scatr_pkg::ERR_NONE) begin
            result.decode_ok           = 1'b1;
            result.error_code          = scatr_pkg::ERR_NONE;
            result.default_protocol    = sr.s.current_protocol;
            result.available_protocols = sr.s.protocol_mask;
            result.convention          = sr.s.coding_convention;
            result.history_length      = sr.s.history_count;
        end else begin
            result.decode_ok           = 1'b0;
            result.error_code          = sr.err;
            result.default_protocol    = scatr_pkg::DEF_NONE;
            result.available_protocols = 4'd0;
            result.convention          = scatr_pkg::CONV_NONE;
            result.history_length      = 4'd0;
        end
    end

endmodule

[design/scatr_checker.sv]
module scatr_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       byte_valid,
    input logic       byte_stall,
    input logic [7:0] atr_byte,
    input logic       is_last,
    input logic       result_valid,
    input logic       result_stall,
    input logic       decode_ok,
    input logic [2:0] error_code,
    input logic [1:0] default_protocol,
    input logic [3:0] available_protocols,
    input logic [1:0] convention,
    input logic [3:0] history_length,
    input logic [5:0] atr_length
);

    // A stalled byte stays offered with the same payload.
    a_byte_hold: assert property (@(posedge clk) disable iff (!rst_n)
        byte_valid && byte_stall |=> byte_valid && $stable(atr_byte) && $stable(is_last))
        else $error("byte changed while stalled");

    // A stalled result stays offered.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid)
        else $error("result dropped while stalled");

    // A success carries no error code and a real convention and protocol.
    a_ok_fields: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && decode_ok |-> error_code == scatr_pkg::ERR_NONE
            && (convention == scatr_pkg::CONV_DIRECT || convention == scatr_pkg::CONV_INVERSE)
            && (default_protocol == scatr_pkg::DEF_T0 || default_protocol == scatr_pkg::DEF_T1))
        else $error("inconsistent success result");

    // A failure carries a defined error code and zeroed summary fields.
    a_fail_fields: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !decode_ok |-> error_code != scatr_pkg::ERR_NONE
            && error_code <= scatr_pkg::ERR_TRUNC
            && default_protocol == scatr_pkg::DEF_NONE && available_protocols == 4'd0
            && convention == scatr_pkg::CONV_NONE && history_length == 4'd0)
        else $error("inconsistent failure result");

    // Every result counts at least the byte that caused it.
    a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> atr_length != 6'd0)
        else $error("result with zero length");

endmodule

bind smart_card_atr_parser scatr_checker u_scatr_checker (.*);

[tb/atr_scoreboard_pkg.sv]
`timescale 1ns / 100ps

package atr_tb_pkg;

    // Byte limit of the parser instance under test.
    localparam int ATR_LIMIT = 33;

    // Tracks the parse of each ATR in step with the block and keeps the
    // results it should produce, oldest first.
    class atr_result_scoreboard;

        localparam int STILL_BUSY = -1;

        scatr_pkg::phase_t  step_phase;
        logic [3:0]         pending_ifc;
        int                 group_num;
        logic [3:0]         hist_left;
        logic [3:0]         hist_total;
        int                 consumed;
        logic               ta_present;
        logic [3:0]         ta_nibble;
        logic [1:0]         dflt_prot;
        logic [3:0]         avail_mask;
        logic [1:0]         conv;

        scatr_pkg::result_t pending_results[$];
        int                 fail_count;

        function new();
            fail_count = 0;
            restart();
        endfunction

        function void restart();
            step_phase = scatr_pkg::PH_TS;
            pending_ifc = 4'd0;
            group_num = 1;
            hist_left = 4'd0;
            hist_total = 4'd0;
            consumed = 0;
            ta_present = 1'b0;
            ta_nibble = 4'd0;
            dflt_prot = scatr_pkg::DEF_NONE;
            avail_mask = 4'd0;
            conv = scatr_pkg::CONV_NONE;
        endfunction

        // Closes an interface group; next_y is the presence nibble of the next one.
        function int close_group(logic [3:0] next_y);
            if (consumed > ATR_LIMIT)
                return scatr_pkg::ERR_LONG;
            if (next_y != 4'd0)
            begin
                if (group_num < 63)
                    group_num++;
                pending_ifc = next_y;
                ta_present = 1'b0;
                ta_nibble = 4'd0;
                step_phase = scatr_pkg::PH_IFACE;
                return STILL_BUSY;
            end
            if (dflt_prot == scatr_pkg::DEF_NONE)
            begin
                dflt_prot = scatr_pkg::DEF_T0;
                avail_mask |= scatr_pkg::PROT_T0;
            end
            if (hist_total != 4'd0)
            begin
                hist_left = hist_total;
                step_phase = scatr_pkg::PH_HIST;
                return STILL_BUSY;
            end
            if ((avail_mask & scatr_pkg::PROT_T1) != 4'd0)
            begin
                step_phase = scatr_pkg::PH_TCK;
                return STILL_BUSY;
            end
            return scatr_pkg::ERR_NONE;
        endfunction

        function int take_td(logic [7:0] value);
            logic [3:0] tnum;
            tnum = value[3:0];
            if (dflt_prot == scatr_pkg::DEF_NONE)
            begin
                if (tnum == scatr_pkg::TNUM_T0)
                    dflt_prot = scatr_pkg::DEF_T0;
                else if (tnum == scatr_pkg::TNUM_T1)
                    dflt_prot = scatr_pkg::DEF_T1;
                else
                    return scatr_pkg::ERR_TD;
            end
            if (tnum == scatr_pkg::TNUM_T0)
                avail_mask |= scatr_pkg::PROT_T0;
            else if (tnum == scatr_pkg::TNUM_T1)
                avail_mask |= scatr_pkg::PROT_T1;
            else if (tnum == scatr_pkg::TNUM_T15)
                avail_mask |= scatr_pkg::PROT_T15;
            if (group_num == 2 && ta_present)
            begin
                if (ta_nibble == scatr_pkg::TNUM_T0)
                begin
                    dflt_prot = scatr_pkg::DEF_T0;
                    avail_mask = scatr_pkg::PROT_T0;
                end
                else if (ta_nibble == scatr_pkg::TNUM_T1)
                begin
                    dflt_prot = scatr_pkg::DEF_T1;
                    avail_mask = scatr_pkg::PROT_T1;
                end
                else
                begin
                    return scatr_pkg::ERR_TA2;
                end
            end
            pending_ifc = 4'd0;
            return close_group(value[7:4]);
        endfunction

        function int take_interface(logic [7:0] value);
            if (pending_ifc[0])
            begin
                pending_ifc[0] = 1'b0;
                ta_present = 1'b1;
                ta_nibble = value[3:0];
            end
            else if (pending_ifc[1])
            begin
                pending_ifc[1] = 1'b0;
            end
            else if (pending_ifc[2])
            begin
                pending_ifc[2] = 1'b0;
            end
            else if (pending_ifc[3])
            begin
                return take_td(value);
            end
            else
            begin
                return close_group(4'd0);
            end
            if (pending_ifc == 4'd0)
                return close_group(4'd0);
            return STILL_BUSY;
        endfunction

        // Notes one accepted byte. Returns 1 when the parser acts on it,
        // 0 when it is dropped after a result.
        function bit note_byte(logic [7:0] value, logic last);
            int                 status;
            scatr_pkg::result_t outcome;
            status = STILL_BUSY;
            if (step_phase == scatr_pkg::PH_DRAIN)
            begin
                if (last)
                    restart();
                return 1'b0;
            end
            if (consumed < 63)
                consumed++;

            case (step_phase)
                scatr_pkg::PH_TS:
                begin
                    if (value == scatr_pkg::TS_INVERSE)
                    begin
                        conv = scatr_pkg::CONV_INVERSE;
                        step_phase = scatr_pkg::PH_T0;
                    end
                    else if (value == scatr_pkg::TS_DIRECT)
                    begin
                        conv = scatr_pkg::CONV_DIRECT;
                        step_phase = scatr_pkg::PH_T0;
                    end
                    else
                    begin
                        status = scatr_pkg::ERR_TS;
                    end
                end
                scatr_pkg::PH_T0:
                begin
                    hist_total = value[3:0];
                    group_num = 1;
                    ta_present = 1'b0;
                    ta_nibble = 4'd0;
                    pending_ifc = value[7:4];
                    if (pending_ifc == 4'd0)
                        status = close_group(4'd0);
                    else
                        step_phase = scatr_pkg::PH_IFACE;
                end
                scatr_pkg::PH_IFACE: status = take_interface(value);
                scatr_pkg::PH_HIST:
                begin
                    if (hist_left > 4'd0)
                        hist_left--;
                    if (hist_left == 4'd0)
                    begin
                        if ((avail_mask & scatr_pkg::PROT_T1) != 4'd0)
                            step_phase = scatr_pkg::PH_TCK;
                        else
                            status = scatr_pkg::ERR_NONE;
                    end
                end
                default: status = scatr_pkg::ERR_NONE;
            endcase

            if (status == STILL_BUSY)
            begin
                if (!last)
                    return 1'b1;
                status = scatr_pkg::ERR_TRUNC;
            end

            if (status == scatr_pkg::ERR_NONE)
            begin
                outcome.decode_ok = 1'b1;
                outcome.error_code = scatr_pkg::ERR_NONE;
                outcome.default_protocol = dflt_prot;
                outcome.available_protocols = avail_mask;
                outcome.convention = conv;
                outcome.history_length = hist_total;
            end
            else
            begin
                outcome.decode_ok = 1'b0;
                outcome.error_code = status[2:0];
                outcome.default_protocol = scatr_pkg::DEF_NONE;
                outcome.available_protocols = 4'd0;
                outcome.convention = scatr_pkg::CONV_NONE;
                outcome.history_length = 4'd0;
            end
            outcome.atr_length = consumed[5:0];
            pending_results.push_back(outcome);

            if (last)
                restart();
            else
                step_phase = scatr_pkg::PH_DRAIN;
            return 1'b1;
        endfunction

        function void compare_field(string field, int want, int got);
            if (want != got)
            begin
                $display("%0t: %s mismatch, expected %0d, actual %0d",
                         $time, field, want, got);
                fail_count++;
            end
        endfunction

        function void check_result(scatr_pkg::result_t got);
            scatr_pkg::result_t want;
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual %h", $time, got);
                fail_count++;
                return;
            end
            want = pending_results.pop_front();
            compare_field("decode_ok", want.decode_ok, got.decode_ok);
            compare_field("error_code", want.error_code, got.error_code);
            compare_field("default_protocol", want.default_protocol, got.default_protocol);
            compare_field("available_protocols", want.available_protocols,
                          got.available_protocols);
            compare_field("convention", want.convention, got.convention);
            compare_field("history_length", want.history_length, got.history_length);
            compare_field("atr_length", want.atr_length, got.atr_length);
        endfunction

    endclass

endpackage

[tb/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;

    // Number of parsed bytes the random part runs up to, bytes of the directed part
    // included. Bytes that the parser drops after a result are not counted.
    localparam int TARGET_BYTES = 850;

    logic       clk;
    logic       rst_n;
    logic       byte_valid;
    logic       byte_stall;
    logic [7:0] atr_byte;
    logic       is_last;
    logic       result_valid;
    logic       result_stall;
    logic       decode_ok;
    logic [2:0] error_code;
    logic [1:0] default_protocol;
    logic [3:0] available_protocols;
    logic [1:0] convention;
    logic [3:0] history_length;
    logic [5:0] atr_length;

    atr_tb_pkg::atr_result_scoreboard scoreboard = new();

    // Bytes of the ATR about to be sent.
    logic [7:0] atr_bytes[$];

    int   sent_count = 0;
    int   parsed_count = 0;
    logic quiet;

    // Both sides stop idling for a stretch of the run, so that the parser
    // also sees long runs of back-to-back transactions.
    assign quiet = (sent_count >= 300) && (sent_count < 450);

    smart_card_atr_parser #(
        .MAX_ATR_BYTES(atr_tb_pkg::ATR_LIMIT)
    ) uut (
        .clk                 (clk),
        .rst_n               (rst_n),
        .byte_valid          (byte_valid),
        .byte_stall          (byte_stall),
        .atr_byte            (atr_byte),
        .is_last             (is_last),
        .result_valid        (result_valid),
        .result_stall        (result_stall),
        .decode_ok           (decode_ok),
        .error_code          (error_code),
        .default_protocol    (default_protocol),
        .available_protocols (available_protocols),
        .convention          (convention),
        .history_length      (history_length),
        .atr_length          (atr_length)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Sends one byte transaction. It is called just after a falling edge and
    // returns just after one. Idle cycles, drawn at random, may come first;
    // once valid is raised it stays up with a stable payload until the
    // parser takes the byte.
    task automatic send_byte(input logic [7:0] value, input logic last);
        while (!quiet && $urandom_range(99) < 11)
        begin
            byte_valid <= 1'b0;
            @(negedge clk);
        end
        byte_valid <= 1'b1;
        atr_byte <= value;
        is_last <= last;
        @(posedge clk);
        while (byte_stall)
            @(posedge clk);
        if (scoreboard.note_byte(value, last))
            parsed_count++;
        sent_count++;
        @(negedge clk);
    endtask

    // Sends atr_bytes up to and including last_pos, with is_last on that byte.
    task automatic send_atr(input int last_pos);
        for (int i = 0; i <= last_pos; i++)
            send_byte(atr_bytes[i], i == last_pos);
    endtask

    // Picks a protocol number for a TD byte: mostly T=0 or T=1, sometimes
    // T=15, and now and then any value at all.
    function automatic logic [3:0] pick_protocol();
        int roll;
        roll = $urandom_range(7);
        if (roll < 3)
            return scatr_pkg::TNUM_T0;
        if (roll < 6)
            return scatr_pkg::TNUM_T1;
        if (roll == 6)
            return scatr_pkg::TNUM_T15;
        return 4'($urandom_range(15));
    endfunction

    // Builds a well-formed ATR with random content into atr_bytes. A few
    // start with a random TS, and about one in ten is built with every
    // interface byte present in many groups so that it runs past the limit.
    task automatic make_atr();
        logic [3:0] presence;
        logic [3:0] next_y;
        logic [3:0] hist_k;
        logic [3:0] tnum;
        logic       long_one;
        logic       t1_seen;
        int         group;
        atr_bytes.delete();
        long_one = ($urandom_range(9) == 0);
        t1_seen = 1'b0;
        if ($urandom_range(19) == 0)
            atr_bytes.push_back(8'($urandom_range(255)));
        else
            atr_bytes.push_back($urandom_range(1) ? scatr_pkg::TS_DIRECT
                                                  : scatr_pkg::TS_INVERSE);
        if ($urandom_range(3) == 0)
            hist_k = 4'($urandom_range(15));
        else
            hist_k = 4'($urandom_range(3));
        presence = long_one ? 4'hF : 4'($urandom_range(15));
        atr_bytes.push_back({presence, hist_k});
        group = 1;
        while (presence != 4'd0 && group < 14)
        begin
            if (presence[0])
            begin
                // TA2 mostly names T=0 or T=1, so that the forced mode is reached.
                if (group == 2 && $urandom_range(3) != 0)
                    atr_bytes.push_back({4'($urandom_range(15)), 3'd0, 1'($urandom_range(1))});
                else
                    atr_bytes.push_back(8'($urandom_range(255)));
            end
            if (presence[1])
                atr_bytes.push_back(8'($urandom_range(255)));
            if (presence[2])
                atr_bytes.push_back(8'($urandom_range(255)));
            if (presence[3])
            begin
                if (long_one)
                    next_y = (group < 9 || $urandom_range(3) != 0) ? 4'hF : 4'($urandom_range(15));
                else
                    next_y = ($urandom_range(2) == 0) ? 4'($urandom_range(15)) : 4'd0;
                tnum = pick_protocol();
                if (tnum == scatr_pkg::TNUM_T1)
                    t1_seen = 1'b1;
                atr_bytes.push_back({next_y, tnum});
                presence = next_y;
                group++;
            end
            else
            begin
                presence = 4'd0;
            end
        end
        repeat (hist_k)
            atr_bytes.push_back(8'($urandom_range(255)));
        // The TCK byte; without T=1 it is sometimes sent anyway and dropped.
        if (t1_seen || $urandom_range(3) == 0)
            atr_bytes.push_back(8'($urandom_range(255)));
    endtask

    // Stimulus: reset, a short directed part, then random ATRs.
    initial
    begin
        int mode;
        rst_n = 1'b0;
        byte_valid = 1'b0;
        atr_byte = 8'd0;
        is_last = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // A bad TS that is also the last byte.
        atr_bytes = '{8'h00};
        send_atr(0);
        // An ATR cut short right after T0.
        atr_bytes = '{scatr_pkg::TS_DIRECT, 8'h80};
        send_atr(1);
        // Inverse convention, TD1 selects T=1, two historical bytes and TCK.
        atr_bytes = '{scatr_pkg::TS_INVERSE, 8'h82, 8'h01, 8'hAA, 8'h55, 8'h00};
        send_atr(5);
        // An unsupported first TD protocol on the last byte: the protocol
        // error wins over truncation.
        atr_bytes = '{scatr_pkg::TS_DIRECT, 8'h80, 8'h05};
        send_atr(2);
        // TA2 forces T=1 after TD2 has announced T=15.
        atr_bytes = '{scatr_pkg::TS_DIRECT, 8'h80, 8'h90, 8'h01, 8'h0F, 8'hFF};
        send_atr(5);
        // TA2 names an unsupported protocol.
        atr_bytes = '{scatr_pkg::TS_DIRECT, 8'h80, 8'h90, 8'h02, 8'h00};
        send_atr(4);
        // The shortest valid ATR: no interface bytes, T=0 by default.
        atr_bytes = '{scatr_pkg::TS_DIRECT, 8'h00};
        send_atr(1);

        // Random part. Most transactions belong to well-formed ATRs; some are
        // cut short, some carry trailing bytes that the parser must drop, and
        // some sequences are plain noise.
        while (parsed_count < TARGET_BYTES)
        begin
            mode = $urandom_range(9);
            if (mode == 0)
            begin
                atr_bytes.delete();
                repeat ($urandom_range(6, 1))
                    atr_bytes.push_back(8'($urandom_range(255)));
                send_atr(atr_bytes.size() - 1);
            end
            else
            begin
                make_atr();
                if (mode == 1)
                begin
                    send_atr($urandom_range(atr_bytes.size() - 1));
                end
                else
                begin
                    if (mode == 2)
                        repeat ($urandom_range(3, 1))
                            atr_bytes.push_back(8'($urandom_range(255)));
                    send_atr(atr_bytes.size() - 1);
                end
            end
        end
        byte_valid <= 1'b0;

        // Wait for every expected result, then keep the clock running so that the
        // parser can show any result it should not have produced.
        while (scoreboard.pending_results.size() != 0)
            @(negedge clk);
        repeat (10) @(negedge clk);

        if (scoreboard.fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // Result receiver: stalls at random, except during the quiet stretch.
    initial
    begin
        result_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!rst_n || quiet)
                result_stall <= 1'b0;
            else
                result_stall <= ($urandom_range(99) < 11);
        end
    end

    // Every result transaction is checked against the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
            scoreboard.check_result(scatr_pkg::result_t'({decode_ok, error_code,
                                                          default_protocol,
                                                          available_protocols, convention,
                                                          history_length, atr_length}));
    end

    // A correct run takes well under a tenth of this time.
    initial
    begin
        #2000000;
        $display("simulation failed");
        $finish;
    end

endmodule

[smart_card_atr_parser.f]
design/scatr_pkg.sv
design/scatr_step.sv
design/smart_card_atr_parser.sv
design/scatr_checker.sv
tb/atr_scoreboard_pkg.sv
tb/tb_top.sv
